FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define RMT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmt assertion failed");

// next-cycle implication, disabled while reset is high
`define RMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmt assertion failed");

`endif

FILE: rtl/rmt_pkg.sv
// constants and types for the running median tracker
// no dependencies; used by rmt_cell, the top level and the checker
package rmt_pkg;

   localparam int DEPTH       = 256;
   localparam int CENTER      = DEPTH / 2;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int STORED_CNT_W = 9;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 48;
   localparam int RSP_USER_W  = 1;

   // what one cell shows its neighbors
   typedef struct packed {
      logic               gt;     // held value ranks above the incoming amount
      logic               valid;
      logic [VALUE_W-1:0] value;
   } cell_view_type;

   // control broadcast to every cell
   typedef struct packed {
      logic               load;        // item accepted and store not full
      logic               shift_down;  // lower side makes room (count odd)
      logic [VALUE_W-1:0] amount;
   } cell_ctl_type;

endpackage

FILE: rtl/rmt_cell.sv
// one cell of the centered sorted chain
// depends on rmt_pkg
module rmt_cell
   import rmt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_ctl_type       ctl,
   input  logic               upper_side,  // empty cell counts as +inf when set
   input  cell_view_type      lo_nbr,
   input  cell_view_type      hi_nbr,
   output cell_view_type      view,
   output logic [VALUE_W-1:0] next_value
);

   logic               valid_ff, valid_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               gt;

   assign gt = valid_ff ? (value_ff > ctl.amount) : upper_side;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctl.load) begin
         if (!ctl.shift_down && gt) begin
            // upper part moves up one cell
            if (lo_nbr.gt) begin
               valid_in = lo_nbr.valid;
               value_in = lo_nbr.value;
            end else begin
               valid_in = 1'b1;
               value_in = ctl.amount;
            end
         end else if (ctl.shift_down && !gt) begin
            // lower part moves down one cell
            if (!hi_nbr.gt) begin
               valid_in = hi_nbr.valid;
               value_in = hi_nbr.value;
            end else begin
               valid_in = 1'b1;
               value_in = ctl.amount;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign view       = '{gt: gt, valid: valid_ff, value: value_ff};
   assign next_value = value_in;

endmodule

FILE: rtl/running_median_tracker.sv
// running median tracker top level: chain of sorted cells, count, result register
// depends on rmt_pkg and rmt_cell
//
//  channel  dir  ports                      beat contents
//  req      in   req_tvalid/tready/tdata    amount
//  rsp      out  rsp_tvalid/tready/tdata    median_value, stored_count
//                rsp_tuser                  full_drop
//
// one beat per cycle while req_tready is high: the cells on one side of the new amount shift in the cycle a beat is
// taken unless the store is full; the result appears in the cycle after acceptance, held in the rsp register
// req_tready is high whenever the rsp register is empty or being drained
// reset clears the cell valid bits, the count and the rsp valid flag
// the median sits in the center cell; the chain spreads values around it
module running_median_tracker
   import rmt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] amount
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] median_value, [40:32] stored_count
   output logic [RSP_USER_W-1:0] rsp_tuser    // [0] full_drop
);

   localparam cell_view_type BOUND_LO = '{gt: 1'b0, valid: 1'b0, value: '0};
   localparam cell_view_type BOUND_HI = '{gt: 1'b1, valid: 1'b0, value: '0};

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_median_ff;
   logic [CNT_W-1:0]   rsp_count_ff;
   logic               rsp_drop_ff;

   logic               req_beat;
   logic               full;
   cell_ctl_type       ctl;
   cell_view_type      views [DEPTH];
   logic [VALUE_W-1:0] next_vals [DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(DEPTH));

   // even count: upper side grows; odd count: lower side grows,
   // so the center cell always holds element floor(count/2)
   assign ctl.load       = req_beat && !full;
   assign ctl.shift_down = count_ff[0];
   assign ctl.amount     = req_tdata[VALUE_W-1:0];

   for (genvar c = 0; c < DEPTH; c++) begin : g_cell
      cell_view_type lo_nbr, hi_nbr;
      if (c == 0) begin : g_lo_edge
         assign lo_nbr = BOUND_LO;
      end else begin : g_lo_link
         assign lo_nbr = views[c-1];
      end
      if (c == DEPTH - 1) begin : g_hi_edge
         assign hi_nbr = BOUND_HI;
      end else begin : g_hi_link
         assign hi_nbr = views[c+1];
      end
      rmt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .upper_side (c >= CENTER),
         .lo_nbr     (lo_nbr),
         .hi_nbr     (hi_nbr),
         .view       (views[c]),
         .next_value (next_vals[c])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.load) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (req_beat) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_beat) begin
         rsp_median_ff <= next_vals[CENTER];
         rsp_count_ff  <= count_in;
         rsp_drop_ff   <= full;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - VALUE_W - STORED_CNT_W){1'b0}},
                        STORED_CNT_W'(rsp_count_ff), rsp_median_ff};
   assign rsp_tuser  = rsp_drop_ff;

endmodule

FILE: rtl/rmt_checker.sv
// port-level checks for the running median tracker, bound to the top level
// depends on rmt_pkg and assert_macros.svh
`include "assert_macros.svh"

module rmt_checker
   import rmt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   logic [STORED_CNT_W-1:0] cnt;
   logic [VALUE_W-1:0]      med;
   logic                    rsp_beat;
   logic [STORED_CNT_W-1:0] last_cnt_ff, last_cnt_in;
   logic [VALUE_W-1:0]      last_med_ff, last_med_in;
   logic                    seen_ff, seen_in;

   assign cnt      = rsp_tdata[VALUE_W +: STORED_CNT_W];
   assign med      = rsp_tdata[VALUE_W-1:0];
   assign rsp_beat = rsp_tvalid && rsp_tready;

   always_comb begin
      last_cnt_in = last_cnt_ff;
      last_med_in = last_med_ff;
      seen_in     = seen_ff;
      if (rsp_beat) begin
         last_cnt_in = cnt;
         last_med_in = med;
         seen_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_cnt_ff <= '0;
         seen_ff     <= 1'b0;
      end else begin
         last_cnt_ff <= last_cnt_in;
         seen_ff     <= seen_in;
      end
      last_med_ff <= last_med_in;
   end

   // a stalled result holds
   `RMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // a dropped amount only happens at full count
   `RMT_ASSERT_IMPL(a_drop_full, clock, reset, rsp_tvalid && rsp_tuser[0],
      cnt == STORED_CNT_W'(DEPTH))
   // count grows by one per kept amount and holds on a drop
   `RMT_ASSERT_IMPL(a_cnt_step, clock, reset, rsp_tvalid,
      (rsp_tuser[0] && cnt == last_cnt_ff) ||
      (!rsp_tuser[0] && cnt == last_cnt_ff + STORED_CNT_W'(1)))
   // a drop leaves the median as last reported
   `RMT_ASSERT_IMPL(a_drop_median, clock, reset, rsp_tvalid && rsp_tuser[0] && seen_ff,
      med == last_med_ff)

endmodule

bind running_median_tracker rmt_checker u_rmt_checker (.*);
